[sv/lpsd_pkg.sv]
// types and constants shared by the section deframer modules
// no dependencies

package lpsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned HIDX_W = 3;
	localparam int unsigned LEN_W  = 32;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_HALTED  = 3'b100
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD    = 3'd0,
		KIND_EMPTY      = 3'd1,
		KIND_BAD_MARKER = 3'd2,
		KIND_TRUNCATED  = 3'd3,
		KIND_CLEAN_END  = 3'd4
	} kind_t;

	typedef struct packed {
		phase_t              phase;
		logic [HIDX_W-1:0]   hdr_idx;
		logic [LEN_W-1:0]    remaining;
	} state_t;

	typedef struct packed {
		logic                valid;
		logic [BYTE_W-1:0]   data;
		logic                last;
		kind_t               kind;
	} result_t;

endpackage

[sv/lpsd_in_if.sv]
// byte stream channel into the section deframer
// depends on lpsd_pkg for field widths

interface lpsd_in_if;
	logic                          valid;
	logic                          ready;
	logic [lpsd_pkg::BYTE_W-1:0]   data_byte;
	logic                          stream_end;

	modport source (output valid, data_byte, stream_end, input ready);
	modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

[sv/lpsd_out_if.sv]
// result channel out of the section deframer
// depends on lpsd_pkg for field widths

interface lpsd_out_if;
	logic                          valid;
	logic                          ready;
	logic [lpsd_pkg::BYTE_W-1:0]   out_byte;
	logic                          out_last;
	logic [lpsd_pkg::KIND_W-1:0]   out_kind;

	modport source (output valid, out_byte, out_last, out_kind, input ready);
	modport sink   (input valid, out_byte, out_last, out_kind, output ready);
endinterface

[sv/length_prefixed_section_deframer_unit.sv]
// Section deframer for a byte stream with LENGTH_BYTES little-endian length bytes
// and a zero marker byte per section header. One stream byte (or end-of-stream item)
// is taken per transfer and gives at most one result. Each item passes through the
// input register and then the result register before its result is offered to the
// sink. The block takes one item every cycle, set by the single register for the
// length counter and phase, and stalls only while a result is held in the output
// register and the sink is not ready.
// A bad marker halts the block, dropping bytes until the next end-of-stream item.
// Depends on lpsd_pkg, lpsd_in_if, lpsd_out_if and lpsd_step.

module length_prefixed_section_deframer_unit #(
	parameter int unsigned LENGTH_BYTES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	lpsd_in_if.sink       feed,
	lpsd_out_if.source    result
);

	logic                          v_s1;
	logic [lpsd_pkg::BYTE_W-1:0]   byte_s1;
	logic                          end_s1;

	lpsd_pkg::state_t              state_q;
	lpsd_pkg::state_t              state_nxt;
	lpsd_pkg::result_t             step_res;

	logic                          res_v_q;
	logic [lpsd_pkg::BYTE_W-1:0]   res_byte_q;
	logic                          res_last_q;
	lpsd_pkg::kind_t               res_kind_q;

	logic                          adv;
	logic                          fire_s1;

	// stage 1 moves on when the result register is empty or being drained
	assign adv     = !res_v_q || result.ready;
	assign fire_s1 = v_s1 && adv;
	assign feed.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (feed.ready) begin
			v_s1 <= feed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			byte_s1 <= feed.data_byte;
			end_s1  <= feed.stream_end;
		end
	end

	lpsd_step #(
		.LENGTH_BYTES (LENGTH_BYTES)
	) u_step (
		.cur        (state_q),
		.data_byte  (byte_s1),
		.stream_end (end_s1),
		.nxt        (state_nxt),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= lpsd_pkg::PH_HEADER;
			state_q.hdr_idx   <= '0;
			state_q.remaining <= '0;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv) begin
			res_v_q <= v_s1 && step_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && step_res.valid) begin
			res_byte_q <= step_res.data;
			res_last_q <= step_res.last;
			res_kind_q <= step_res.kind;
		end
	end

	assign result.valid    = res_v_q;
	assign result.out_byte = res_byte_q;
	assign result.out_last = res_last_q;
	assign result.out_kind = res_kind_q;

	// payload phase always has bytes still due
	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == lpsd_pkg::PH_PAYLOAD |-> state_q.remaining != '0)
		else $error("payload phase with zero bytes remaining");

	a_hdr_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hdr_idx <= lpsd_pkg::HIDX_W'(LENGTH_BYTES))
		else $error("header index past header length");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && end_s1 |=> state_q.phase == lpsd_pkg::PH_HEADER
			&& state_q.hdr_idx == '0 && state_q.remaining == '0)
		else $error("end of stream did not clear header state");

	a_bad_marker_halts: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && step_res.valid && step_res.kind == lpsd_pkg::KIND_BAD_MARKER
			|=> state_q.phase == lpsd_pkg::PH_HALTED && res_v_q)
		else $error("bad marker did not halt with a result");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && state_q.phase == lpsd_pkg::PH_HALTED |-> !step_res.valid)
		else $error("result produced while halted");

endmodule

[sv/lpsd_step.sv]
// per-byte framing logic: next state and optional result for one stream item
// depends on lpsd_pkg

module lpsd_step #(
	parameter int unsigned LENGTH_BYTES = 4
) (
	input  lpsd_pkg::state_t              cur,
	input  logic [lpsd_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          stream_end,
	output lpsd_pkg::state_t              nxt,
	output lpsd_pkg::result_t             res
);

	localparam logic [lpsd_pkg::HIDX_W-1:0] HdrLen = lpsd_pkg::HIDX_W'(LENGTH_BYTES);

	logic [lpsd_pkg::LEN_W-1:0] dec;
	logic [1:0]                 lane;

	assign dec  = cur.remaining - lpsd_pkg::LEN_W'(1);
	assign lane = cur.hdr_idx[1:0];

	always_comb begin
		nxt       = cur;
		res.valid = 1'b0;
		res.data  = '0;
		res.last  = 1'b0;
		res.kind  = lpsd_pkg::KIND_PAYLOAD;
		if (stream_end) begin
			nxt.phase     = lpsd_pkg::PH_HEADER;
			nxt.hdr_idx   = '0;
			nxt.remaining = '0;
			priority if (cur.phase == lpsd_pkg::PH_HALTED) begin
				res.valid = 1'b0;
			end else if (cur.phase == lpsd_pkg::PH_PAYLOAD) begin
				res.valid = 1'b1;
				res.kind  = lpsd_pkg::KIND_TRUNCATED;
			end else begin
				res.valid = 1'b1;
				res.kind  = lpsd_pkg::KIND_CLEAN_END;
			end
		end else begin
			priority if (cur.phase == lpsd_pkg::PH_HALTED) begin
				res.valid = 1'b0;
			end else if (cur.phase == lpsd_pkg::PH_PAYLOAD) begin
				nxt.remaining = dec;
				res.valid     = 1'b1;
				res.data      = data_byte;
				if (dec == '0) begin
					nxt.phase   = lpsd_pkg::PH_HEADER;
					nxt.hdr_idx = '0;
					res.last    = 1'b1;
				end
			end else begin
				// header phase, also covers any unused phase code
				nxt.phase = lpsd_pkg::PH_HEADER;
				if (cur.hdr_idx < HdrLen) begin
					// length bytes arrive least significant first
					nxt.remaining[lane*8 +: 8] = cur.remaining[lane*8 +: 8] | data_byte;
					nxt.hdr_idx = cur.hdr_idx + lpsd_pkg::HIDX_W'(1);
				end else if (data_byte != '0) begin
					nxt.phase     = lpsd_pkg::PH_HALTED;
					nxt.hdr_idx   = '0;
					nxt.remaining = '0;
					res.valid     = 1'b1;
					res.kind      = lpsd_pkg::KIND_BAD_MARKER;
				end else begin
					nxt.hdr_idx = '0;
					if (cur.remaining == '0) begin
						res.valid = 1'b1;
						res.last  = 1'b1;
						res.kind  = lpsd_pkg::KIND_EMPTY;
					end else begin
						nxt.phase = lpsd_pkg::PH_PAYLOAD;
					end
				end
			end
		end
	end

endmodule
